[design/sha256_message_digest_defines.svh]
// ----------------------------------------------------------------------------
// sha256_message_digest_defines
// Assertion macros for the SHA-256 message digest block.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH
`ifndef SYNTHESIS
`define SMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 digest block.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Handshake between sequencer and round core
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Padding phases: marker byte, zeros then length, zeros up to block end
    localparam logic [2:0] PAD_MARK = 3'd0;
    localparam logic [2:0] PAD_FILL = 3'd1;
    localparam logic [2:0] PAD_WRAP = 3'd2;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[design/sha256_message_digest.sv]
// One byte per beat; a byte that does not fill a block is taken without holding
// the input, and a beat that fills a block holds the input while the core runs
// its 64 rounds and reports completion and the result is folded into the
// hash. A last beat then pads one byte per cycle (with one or
// two compressions) and emits eight digest beats, one per cycle as the output
// side accepts them. The single round core sets the rate.
// ----------------------------------------------------------------------------
// sha256_message_digest
// Byte-serial SHA-256: packs, pads, compresses and emits the 256-bit digest.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_message_digest_defines.svh"
module sha256_message_digest
    import sha256_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    state_t        state_reg, state_next;
    logic [255:0]  hash_reg, hash_next;
    logic [511:0]  buf_reg, buf_next;
    logic [63:0]   len_reg, len_next;
    logic [5:0]    pos_reg, pos_next;
    logic          last_reg, last_next;
    logic [2:0]    pad_reg, pad_next;
    logic [2:0]    widx_reg, widx_next;
    logic          core_start;
    core_ctl_t     core_ctl;
    logic [255:0]  core_vars;

    logic          put_en;
    logic [7:0]    put_byte;
    logic          in_fire;
    logic [511:0]  buf_put;
    logic [255:0]  hash_sum;

    sha256_round_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (core_start),
        .block    (buf_put),
        .hash_in  (hash_reg),
        .ctl      (core_ctl),
        .vars_out (core_vars)
    );

    assign in_fire = in_valid && in_ready;

    // Pick the byte to place: message byte, pad marker, zeros or length
    always_comb
    begin
        put_en   = 1'b0;
        put_byte = 8'h00;
        if (state_reg == ST_IDLE && in_fire && in_data.has_byte)
        begin
            put_en   = 1'b1;
            put_byte = in_data.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            put_en = 1'b1;
            case (pad_reg)
                PAD_MARK:
                    put_byte = PAD_BYTE;
                PAD_FILL:
                    if (pos_reg >= 6'd56)
                        put_byte = len_reg[8*(63 - pos_reg) +: 8];
                    else
                        put_byte = 8'h00;
                default:
                    put_byte = 8'h00;
            endcase
        end
        buf_put = buf_reg;
        if (put_en)
            buf_put[8*(63 - pos_reg) +: 8] = put_byte;
        for (int i = 0; i < 8; i++)
            hash_sum[32*i +: 32] = hash_reg[32*i +: 32] + core_vars[32*i +: 32];
    end

    assign core_start = put_en && (pos_reg == 6'd63);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    if (core_start)
                        state_next = ST_ROUND;
                    else if (in_data.is_last)
                        state_next = ST_PAD;
                end
            ST_ROUND:
                if (core_ctl.done)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (last_reg)
                    state_next = ST_PAD;
                else if (pad_reg == PAD_FILL)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            ST_PAD:
                if (core_start)
                    state_next = ST_ROUND;
            ST_EMIT:
                if (out_ready && widx_reg == 3'd7)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        hash_next = hash_reg;
        buf_next  = buf_put;
        len_next  = len_reg;
        pos_next  = put_en ? pos_reg + 6'd1 : pos_reg;
        last_next = last_reg;
        pad_next  = pad_reg;
        widx_next = widx_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    last_next = in_data.is_last;
                    pad_next  = PAD_MARK;
                    if (in_data.has_byte)
                        len_next = len_reg + 64'd8;
                end
            ST_FOLD:
            begin
                hash_next = hash_sum;
                // Final fold goes straight to output
                if (!last_reg && pad_reg == PAD_FILL)
                begin
                    pad_next  = PAD_MARK;
                    widx_next = '0;
                end
            end
            ST_PAD:
                case (pad_reg)
                    PAD_MARK:
                        // Marker too late for the length: zero out this block first
                        pad_next = (pos_reg inside {[6'd56:6'd62]}) ? PAD_WRAP : PAD_FILL;
                    PAD_WRAP:
                        if (pos_reg == 6'd63)
                            pad_next = PAD_FILL;
                    default:
                        // Length complete: block goes to compression, then output
                        if (pos_reg == 6'd63)
                            last_next = 1'b0;
                endcase
            ST_EMIT:
                if (out_ready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            hash_next[255 - 32*i -: 32] = init_hash(3'(i));
                        len_next = '0;
                        pos_next = '0;
                    end
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++)
                hash_reg[255 - 32*i -: 32] <= init_hash(3'(i));
            len_reg  <= '0;
            pos_reg  <= '0;
            last_reg <= 1'b0;
            pad_reg  <= PAD_MARK;
            widx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
            pad_reg   <= pad_next;
            widx_reg  <= widx_next;
        end
    end

    // Outputs
    always_comb
    begin
        in_ready             = (state_reg == ST_IDLE);
        out_valid            = (state_reg == ST_EMIT);
        out_data.digest_word = hash_reg[255 - 32*widx_reg -: 32];
        out_data.word_index  = widx_reg;
        out_data.last_word   = (widx_reg == 3'd7);
    end

    `SMD_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `SMD_ASSERT_IMPL(a_core_idle_start, clk, rst_n, core_start, !core_ctl.busy)
    `SMD_ASSERT_NEXT(a_done_fold, clk, rst_n, core_ctl.done, state_reg == ST_FOLD)

endmodule
`default_nettype wire

[design/sha256_round_core.sv]
// ----------------------------------------------------------------------------
// sha256_round_core
// Shared compression unit: one SHA-256 round per cycle, 64 rounds per block,
// with the rolling 16-word schedule window and the working variables.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_round_core
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [511:0] block,
    input  wire logic [255:0] hash_in,
    output core_ctl_t        ctl,
    output logic [255:0]     vars_out
);

    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] var_reg [8];
    logic [31:0] var_next [8];
    logic [6:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [31:0] w15, w2, s0, s1, w_new, w_cur;
    logic [31:0] sig0, sig1, ch, maj, t1, t2;
    logic [3:0]  slot;

    // Schedule word and round function
    always_comb
    begin
        slot  = round_reg[3:0];
        w15   = win_reg[slot + 4'd1];
        w2    = win_reg[slot + 4'd14];
        s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        w_new = win_reg[slot] + s0 + win_reg[slot + 4'd9] + s1;
        w_cur = (round_reg >= 7'd16) ? w_new : win_reg[slot];
        sig1  = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1    = var_reg[7] + sig1 + ch + round_k(round_reg[5:0]) + w_cur;
        sig0  = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);
        t2    = sig0 + maj;
    end

    // Load on start, advance one round while busy
    always_comb
    begin
        win_next   = win_reg;
        var_next   = var_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            for (int i = 0; i < 16; i++)
                win_next[i] = block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++)
                var_next[i] = hash_in[255 - 32*i -: 32];
            round_next = 7'd0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            win_next[slot] = w_cur;
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
            round_next  = round_reg + 7'd1;
            if (round_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        var_reg <= var_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            round_reg <= round_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        ctl.start = start;
        ctl.busy  = busy_reg;
        ctl.done  = done_reg;
        for (int i = 0; i < 8; i++)
            vars_out[255 - 32*i -: 32] = var_reg[i];
    end

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte-serial SHA-256 bench: feeds messages, predicts digests, checks beats.
// ----------------------------------------------------------------------------
module tb;
    import sha256_pkg::*;

    // Digest predictor and queue of expected digest beats
    class digest_board;
        logic [31:0] hash_st [8];
        logic [31:0] blk [16];
        logic [63:0] msg_bits;
        int unsigned pos;
        out_item_t   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 8; i++) hash_st[i] = init_hash(i[2:0]);
            for (int i = 0; i < 16; i++) blk[i] = '0;
            msg_bits = '0;
            pos = 0;
            errors = 0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2, x;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 0; i < 8; i++) v[i] = hash_st[i];
            for (int r = 0; r < 64; r++)
            begin
                if (r >= 16)
                begin
                    x = w[(r - 15) & 15];
                    s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
                    x = w[(r - 2) & 15];
                    s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
                    w[r & 15] = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
                end
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r & 15];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_st[i] += v[i];
        endfunction

        function void absorb(logic [7:0] b);
            int sh;
            sh = (3 - (pos % 4)) * 8;
            if (pos % 4 == 0) blk[pos / 4] = 32'(b) << 24;
            else blk[pos / 4] |= 32'(b) << sh;
            pos++;
            if (pos == 64)
            begin
                compress();
                pos = 0;
            end
        endfunction

        // Note an accepted input beat
        function void note_input(in_item_t it);
            logic [63:0] len;
            out_item_t o;
            if (it.has_byte)
            begin
                absorb(it.data_byte);
                msg_bits += 8;
            end
            if (!it.is_last) return;
            len = msg_bits;
            absorb(PAD_BYTE);
            while (pos != 56) absorb(8'h00);
            for (int k = 7; k >= 0; k--) absorb(len[8 * k +: 8]);
            for (int k = 0; k < 8; k++)
            begin
                o.digest_word = hash_st[k];
                o.word_index = k[2:0];
                o.last_word = (k == 7);
                pending.insert(pending.size(), o);
            end
            for (int i = 0; i < 8; i++) hash_st[i] = init_hash(i[2:0]);
            msg_bits = '0;
            pos = 0;
        endfunction

        // Check an accepted output beat against the oldest expectation
        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected digest beat %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.digest_word !== e.digest_word)
            begin
                $error("digest_word exp %h got %h", e.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== e.word_index)
            begin
                $error("word_index exp %0d got %0d", e.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== e.last_word)
            begin
                $error("last_word exp %0d got %0d", e.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    digest_board board;
    bit          calm;

    sha256_message_digest i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function bit idle_now();
        return !calm && ($urandom_range(0, 99) < 24);
    endfunction

    // Send one beat, with an optional random gap before it
    task automatic send_beat(logic [7:0] b, logic hb, logic lst);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, has_byte: hb, is_last: lst};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(in_data);
    endtask

    // Send a message of random bytes, optionally closed by an empty beat
    task automatic send_message(int n, bit empty_end);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(0, 255)), 1'b1, !empty_end && (i == n - 1));
        if (empty_end || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Receive side: random stalls, check each accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) board.check_result(out_data);
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        calm = 1'b0;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, extremes, idle beats, block boundaries
        send_message(0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(64, 1'b0);

        // Random messages, mostly short, with a calm stretch in the middle
        for (int m = 0; m < 14; m++)
        begin
            calm = (m >= 5 && m < 9);
            case ($urandom_range(0, 3))
                0: send_message(int'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
                1: send_message(int'($urandom_range(50, 70)), 1'($urandom_range(0, 1)));
                default:
                begin
                    for (int k = int'($urandom_range(0, 20)); k > 0; k--)
                        send_beat(8'($urandom_range(0, 255)),
                                  $urandom_range(0, 3) != 0, 1'b0);
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                end
            endcase
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
